// ===== sv/wrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Williams %R threshold tracker.
// No dependencies; used by every module of the block.
package wrt_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int PCT_W      = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int Q_W        = 15;
  localparam int PROD_W     = DIFF_W + Q_W;
  localparam int REM_W      = DIFF_W + 1;
  localparam int STEP_W     = $clog2(Q_W);

  localparam logic [Q_W-1:0]      SCALE      = Q_W'(25600);
  localparam logic [PCT_W-1:0]    NEUTRAL    = PCT_W'(-12800);
  localparam logic [LEN_W-1:0]    WL_RESET   = LEN_W'(14);
  localparam logic [LEN_W-1:0]    WU_RESET   = LEN_W'(14);
  localparam logic [PCT_W-1:0]    HI_RESET   = PCT_W'(-5120);
  localparam logic [PCT_W-1:0]    LO_RESET   = PCT_W'(-20480);
  localparam logic [LEN_W-1:0]    WIN_MAX_L  = LEN_W'(WINDOW_MAX);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH  = 2'd0,
    REG_WARMUP_COUNT   = 2'd1,
    REG_HIGH_THRESHOLD = 2'd2,
    REG_LOW_THRESHOLD  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [LEN_W-1:0] window_length;
    logic [LEN_W-1:0] warmup_count;
    logic [PCT_W-1:0] high_threshold;
    logic [PCT_W-1:0] low_threshold;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    fill;
    logic                ready;
  } entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == '1) ? c : c + CNT_W'(1);
  endfunction

endpackage

// ===== sv/williams_r_threshold_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the Williams %R threshold tracker: config registers and wiring.
// Depends on wrt_pkg, wrt_front, wrt_fifo, wrt_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_stall   | in_sample
//   out     | out_valid / out_stall | out_percent_r, flags, events, three totals
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A ready sample passes through the back end in order: pop and ring write, one read
// per window entry, multiply, 15 divide steps, output load.
// A sample before warmup goes straight from pop and ring write to output load.
// The front and a two-entry queue keep taking transfers while the back end works;
// in_stall rises when the queue is full, and out_stall holds the back end at its load.
// Reset (rst_n low, synchronous) clears control state and loads default registers.
// A config write clears ring position and fill; cfg_ready is always high.
module williams_r_threshold_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wrt_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wrt_pkg::PCT_W-1:0]       out_percent_r,
  output logic                            out_ready_res,
  output logic                            out_above_flag,
  output logic                            out_below_flag,
  output logic                            out_above_event,
  output logic                            out_below_event,
  output logic [wrt_pkg::CNT_W-1:0]       out_above_total,
  output logic [wrt_pkg::CNT_W-1:0]       out_below_total,
  output logic [wrt_pkg::CNT_W-1:0]       out_sample_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  wrt_pkg::cfg_t   cfg_r;
  wrt_pkg::entry_t push_entry, head_entry;
  logic            cfg_we;
  logic            q_full, q_empty, q_push, q_pop;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length  <= wrt_pkg::WL_RESET;
      cfg_r.warmup_count   <= wrt_pkg::WU_RESET;
      cfg_r.high_threshold <= wrt_pkg::HI_RESET;
      cfg_r.low_threshold  <= wrt_pkg::LO_RESET;
    end else if (cfg_we) begin
      case (wrt_pkg::reg_idx_t'(cfg_index))
        wrt_pkg::REG_WINDOW_LENGTH:
          cfg_r.window_length  <= cfg_data[wrt_pkg::LEN_W-1:0];
        wrt_pkg::REG_WARMUP_COUNT:
          cfg_r.warmup_count   <= cfg_data[wrt_pkg::LEN_W-1:0];
        wrt_pkg::REG_HIGH_THRESHOLD:
          cfg_r.high_threshold <= cfg_data[wrt_pkg::PCT_W-1:0];
        wrt_pkg::REG_LOW_THRESHOLD:
          cfg_r.low_threshold  <= cfg_data[wrt_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  wrt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_we),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  wrt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head_entry),
    .empty     (q_empty)
  );

  wrt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_head           (head_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_percent_r    (out_percent_r),
    .out_ready_res    (out_ready_res),
    .out_above_flag   (out_above_flag),
    .out_below_flag   (out_below_flag),
    .out_above_event  (out_above_event),
    .out_below_event  (out_below_event),
    .out_above_total  (out_above_total),
    .out_below_total  (out_below_total),
    .out_sample_total (out_sample_total)
  );

endmodule

// ===== sv/wrt_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, tracks ring position and fill, decides readiness.
// Depends on wrt_pkg.
module wrt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clear,
  input  wrt_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wrt_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                           q_full,
  output logic                           q_push,
  output wrt_pkg::entry_t                q_entry
);

  logic [wrt_pkg::ADDR_W-1:0] write_pos_r, write_pos_nxt;
  logic [wrt_pkg::LEN_W-1:0]  fill_r, fill_nxt;
  logic [wrt_pkg::LEN_W-1:0]  sz;
  logic [wrt_pkg::LEN_W-1:0]  pos_inc;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    if (cfg.window_length == '0) begin
      sz = wrt_pkg::LEN_W'(1);
    end else if (cfg.window_length > wrt_pkg::WIN_MAX_L) begin
      sz = wrt_pkg::WIN_MAX_L;
    end else begin
      sz = cfg.window_length;
    end
    pos_inc       = {1'b0, write_pos_r} + wrt_pkg::LEN_W'(1);
    write_pos_nxt = (pos_inc >= sz) ? '0 : pos_inc[wrt_pkg::ADDR_W-1:0];
    fill_nxt      = (fill_r < sz) ? fill_r + wrt_pkg::LEN_W'(1) : fill_r;
    q_entry.sample = in_sample;
    q_entry.addr   = write_pos_r;
    q_entry.fill   = fill_nxt;
    q_entry.ready  = (fill_nxt >= cfg.warmup_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      write_pos_r <= '0;
      fill_r      <= '0;
    end else if (q_push) begin
      write_pos_r <= write_pos_nxt;
      fill_r      <= fill_nxt;
    end
  end

endmodule

// ===== sv/wrt_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue carrying classified samples from front to back end.
// Depends on wrt_pkg.
module wrt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wrt_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output wrt_pkg::entry_t head,
  output logic            empty
);

  wrt_pkg::entry_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/wrt_back.sv =====
`timescale 1ns / 1ps
// Back end: ring memory, min/max scan, serial divide, flags, counters, output register.
// Depends on wrt_pkg.
module wrt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wrt_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  input  wrt_pkg::entry_t               q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wrt_pkg::PCT_W-1:0]     out_percent_r,
  output logic                          out_ready_res,
  output logic                          out_above_flag,
  output logic                          out_below_flag,
  output logic                          out_above_event,
  output logic                          out_below_event,
  output logic [wrt_pkg::CNT_W-1:0]     out_above_total,
  output logic [wrt_pkg::CNT_W-1:0]     out_below_total,
  output logic [wrt_pkg::CNT_W-1:0]     out_sample_total
);

  wrt_pkg::bk_state_t state_r, state_nxt;

  logic [wrt_pkg::SAMPLE_W-1:0] mem [wrt_pkg::WINDOW_MAX];
  logic [wrt_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                         rd_vld_r;

  logic [wrt_pkg::SAMPLE_W-1:0] sample_r;
  logic [wrt_pkg::LEN_W-1:0]    n_r;
  logic                         ready_r;
  logic [wrt_pkg::LEN_W-1:0]    idx_r;
  logic                         first_r;
  logic signed [wrt_pkg::SAMPLE_W-1:0] hh_r, ll_r;
  logic [wrt_pkg::DIFF_W-1:0]   range_r;
  logic [wrt_pkg::REM_W-1:0]    rem_r;
  logic [wrt_pkg::Q_W-1:0]      low_r;
  logic [wrt_pkg::Q_W-1:0]      q_r;
  logic [wrt_pkg::STEP_W-1:0]   step_r;

  logic was_above_r, was_below_r;
  logic [wrt_pkg::CNT_W-1:0] above_cnt_r, below_cnt_r, sample_cnt_r;

  logic out_valid_r;
  logic out_free;
  logic mem_we, rd_issue, load_out;

  logic signed [wrt_pkg::SAMPLE_W-1:0] rd_s;
  logic [wrt_pkg::DIFF_W-1:0]   diff;
  logic [wrt_pkg::PROD_W-1:0]   prod;
  logic [wrt_pkg::REM_W-1:0]    trial;
  logic                         take;

  logic [wrt_pkg::PCT_W-1:0]    pr;
  logic ab, bl, aev, bev;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign rd_s      = $signed(rd_data_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wrt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_head.ready ? wrt_pkg::BK_SCAN : wrt_pkg::BK_DONE;
        end
      end
      wrt_pkg::BK_SCAN: begin
        if (rd_vld_r && idx_r == n_r) begin
          state_nxt = wrt_pkg::BK_MUL;
        end
      end
      wrt_pkg::BK_MUL:  state_nxt = wrt_pkg::BK_DIV;
      wrt_pkg::BK_DIV: begin
        if (step_r == wrt_pkg::STEP_W'(wrt_pkg::Q_W - 1)) begin
          state_nxt = wrt_pkg::BK_DONE;
        end
      end
      wrt_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = wrt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = wrt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    rd_issue = 1'b0;
    load_out = 1'b0;
    case (state_r)
      wrt_pkg::BK_IDLE: begin
        q_pop  = !q_empty;
        mem_we = !q_empty;
      end
      wrt_pkg::BK_SCAN: rd_issue = (idx_r < n_r);
      wrt_pkg::BK_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    diff  = wrt_pkg::DIFF_W'($signed(hh_r) - $signed(sample_r));
    prod  = wrt_pkg::PROD_W'(diff) * wrt_pkg::PROD_W'(wrt_pkg::SCALE);
    trial = {rem_r[wrt_pkg::REM_W-2:0], low_r[wrt_pkg::Q_W-1]};
    take  = (trial >= {1'b0, range_r});
  end

  always_comb begin
    pr  = wrt_pkg::NEUTRAL;
    ab  = 1'b0;
    bl  = 1'b0;
    aev = 1'b0;
    bev = 1'b0;
    if (ready_r) begin
      if (range_r != '0) begin
        pr = wrt_pkg::PCT_W'(0) - {1'b0, q_r};
      end
      ab  = $signed(pr) > $signed(cfg.high_threshold);
      bl  = $signed(pr) < $signed(cfg.low_threshold);
      aev = ab && !was_above_r;
      bev = bl && !was_below_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_head.addr] <= q_head.sample;
    end
    if (rd_issue) begin
      rd_data_r <= mem[idx_r[wrt_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample_r <= q_head.sample;
      n_r      <= q_head.fill;
      ready_r  <= q_head.ready;
      idx_r    <= '0;
      first_r  <= 1'b1;
      range_r  <= '0;
    end
    if (rd_issue) begin
      idx_r <= idx_r + wrt_pkg::LEN_W'(1);
    end
    if (rd_vld_r) begin
      first_r <= 1'b0;
      if (first_r || rd_s > hh_r) begin
        hh_r <= rd_s;
      end
      if (first_r || rd_s < ll_r) begin
        ll_r <= rd_s;
      end
    end
    if (state_r == wrt_pkg::BK_MUL) begin
      range_r <= wrt_pkg::DIFF_W'($signed(hh_r) - $signed(ll_r));
      rem_r   <= {1'b0, prod[wrt_pkg::PROD_W-1:wrt_pkg::Q_W]};
      low_r   <= prod[wrt_pkg::Q_W-1:0];
      q_r     <= '0;
      step_r  <= '0;
    end
    if (state_r == wrt_pkg::BK_DIV) begin
      rem_r  <= take ? trial - {1'b0, range_r} : trial;
      low_r  <= {low_r[wrt_pkg::Q_W-2:0], 1'b0};
      q_r    <= {q_r[wrt_pkg::Q_W-2:0], take};
      step_r <= step_r + wrt_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_percent_r    <= pr;
      out_ready_res    <= ready_r;
      out_above_flag   <= ab;
      out_below_flag   <= bl;
      out_above_event  <= aev;
      out_below_event  <= bev;
      out_above_total  <= aev ? wrt_pkg::sat_inc(above_cnt_r) : above_cnt_r;
      out_below_total  <= bev ? wrt_pkg::sat_inc(below_cnt_r) : below_cnt_r;
      out_sample_total <= wrt_pkg::sat_inc(sample_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wrt_pkg::BK_IDLE;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      was_above_r  <= 1'b0;
      was_below_r  <= 1'b0;
      above_cnt_r  <= '0;
      below_cnt_r  <= '0;
      sample_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_issue;
      if (load_out) begin
        out_valid_r  <= 1'b1;
        sample_cnt_r <= wrt_pkg::sat_inc(sample_cnt_r);
        if (aev) begin
          above_cnt_r <= wrt_pkg::sat_inc(above_cnt_r);
        end
        if (bev) begin
          below_cnt_r <= wrt_pkg::sat_inc(below_cnt_r);
        end
        if (ready_r) begin
          was_above_r <= ab;
          was_below_r <= bl;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for williams_r_threshold_tracker: directed and random samples
// against a cycle-free %R predictor kept in the bench. Depends on wrt_pkg and the RTL.
module tb;

  typedef struct {
    logic [wrt_pkg::PCT_W-1:0] pct;
    logic                      ready;
    logic                      above;
    logic                      below;
    logic                      above_ev;
    logic                      below_ev;
    logic [wrt_pkg::CNT_W-1:0] above_cnt;
    logic [wrt_pkg::CNT_W-1:0] below_cnt;
    logic [wrt_pkg::CNT_W-1:0] sample_cnt;
  } pct_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [wrt_pkg::SAMPLE_W-1:0]   in_sample = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [wrt_pkg::PCT_W-1:0]      out_percent_r;
  logic                           out_ready_res;
  logic                           out_above_flag;
  logic                           out_below_flag;
  logic                           out_above_event;
  logic                           out_below_event;
  logic [wrt_pkg::CNT_W-1:0]      out_above_total;
  logic [wrt_pkg::CNT_W-1:0]      out_below_total;
  logic [wrt_pkg::CNT_W-1:0]      out_sample_total;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [wrt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wrt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  williams_r_threshold_tracker dut (.*);

  always #1 clk = ~clk;

  // bench copy of the block state
  logic signed [wrt_pkg::SAMPLE_W-1:0] hist [wrt_pkg::WINDOW_MAX];
  int                                  hist_pos = 0;
  int                                  hist_fill = 0;
  bit                                  prev_above = 0;
  bit                                  prev_below = 0;
  logic [wrt_pkg::CNT_W-1:0]           n_above = '0;
  logic [wrt_pkg::CNT_W-1:0]           n_below = '0;
  logic [wrt_pkg::CNT_W-1:0]           n_samples = '0;
  logic [6:0]                          cfg_win = 7'd14;
  logic [6:0]                          cfg_warm = 7'd14;
  logic signed [wrt_pkg::PCT_W-1:0]    cfg_hi = -16'sd5120;
  logic signed [wrt_pkg::PCT_W-1:0]    cfg_lo = -16'sd20480;

  pct_result_t pct_due [$];

  int  misses = 0;
  int  results_seen = 0;
  int  ready_seen = 0;
  int  above_entries = 0;
  int  below_entries = 0;
  int  settings_loaded = 0;
  int  burst_left = 0;
  bit  in_on = 0;
  int  walk = 0;
  int  walk_step = 100;
  int  hold_left = 0;
  int  hold_val = 0;
  int  stall_mode = 0;
  int  stall_left = 0;
  int  stall_run = 0;

  function automatic logic [wrt_pkg::CNT_W-1:0] bump(input logic [wrt_pkg::CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  task automatic track_sample(input logic signed [wrt_pkg::SAMPLE_W-1:0] s);
    int          eff;
    int          hh;
    int          ll;
    int          v;
    int          pr;
    longint      num;
    pct_result_t r;
    eff = (cfg_win == 0) ? 1 :
          ((cfg_win > wrt_pkg::WINDOW_MAX) ? wrt_pkg::WINDOW_MAX : int'(cfg_win));
    hist[hist_pos % eff] = s;
    hist_pos = (hist_pos + 1) % eff;
    if (hist_fill < eff) hist_fill++;
    pr = -12800;
    r.ready = (hist_fill >= cfg_warm);
    r.above = 0;
    r.below = 0;
    r.above_ev = 0;
    r.below_ev = 0;
    if (r.ready) begin
      hh = hist[(hist_pos + eff - hist_fill) % eff];
      ll = hh;
      for (int i = 0; i < hist_fill; i++) begin
        v = hist[(hist_pos + eff - hist_fill + i) % eff];
        if (v > hh) hh = v;
        if (v < ll) ll = v;
      end
      if (hh != ll) begin
        num = longint'(hh - int'(s)) * 25600;
        pr = -int'(num / longint'(hh - ll));
      end
      r.above = (pr > cfg_hi);
      r.below = (pr < cfg_lo);
      if (r.above && !prev_above) begin
        r.above_ev = 1;
        n_above = bump(n_above);
      end
      if (r.below && !prev_below) begin
        r.below_ev = 1;
        n_below = bump(n_below);
      end
      prev_above = r.above;
      prev_below = r.below;
    end
    n_samples = bump(n_samples);
    r.pct = pr[wrt_pkg::PCT_W-1:0];
    r.above_cnt = n_above;
    r.below_cnt = n_below;
    r.sample_cnt = n_samples;
    pct_due.push_back(r);
  endtask

  task automatic send_sample(input logic signed [wrt_pkg::SAMPLE_W-1:0] s);
    int gap;
    in_valid <= 1'b1;
    in_sample <= s;
    in_on = 1;
    do @(posedge clk); while (in_stall);
    track_sample(s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_on = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    if (in_on) begin
      in_valid <= 1'b0;
      in_on = 0;
    end
    while (pct_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input wrt_pkg::reg_idx_t idx,
                           input logic [wrt_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wrt_pkg::REG_WINDOW_LENGTH:  cfg_win = val[6:0];
      wrt_pkg::REG_WARMUP_COUNT:   cfg_warm = val[6:0];
      wrt_pkg::REG_HIGH_THRESHOLD: cfg_hi = val;
      wrt_pkg::REG_LOW_THRESHOLD:  cfg_lo = val;
      default: ;
    endcase
    hist_pos = 0;
    hist_fill = 0;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mask bit i selects register index i
  task automatic load_settings(input int win, input int warm, input int hi, input int lo,
                               input logic [3:0] mask);
    drain();
    if (mask[0]) write_reg(wrt_pkg::REG_WINDOW_LENGTH, wrt_pkg::CFG_DATA_W'(win));
    if (mask[1]) write_reg(wrt_pkg::REG_WARMUP_COUNT, wrt_pkg::CFG_DATA_W'(warm));
    if (mask[2]) write_reg(wrt_pkg::REG_HIGH_THRESHOLD, wrt_pkg::CFG_DATA_W'(hi));
    if (mask[3]) write_reg(wrt_pkg::REG_LOW_THRESHOLD, wrt_pkg::CFG_DATA_W'(lo));
    settings_loaded++;
  endtask

  task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      misses++;
      if (misses <= 10)
        $display("mismatch in %s on result %0d: expected %0h, got %0h",
                 fname, results_seen, want, got);
    end
  endtask

  always @(posedge clk) begin
    pct_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pct_due.size() == 0) begin
        misses++;
        if (misses <= 10) $display("result %0d arrived with nothing pending", results_seen);
      end else begin
        want = pct_due.pop_front();
        if (want.ready) ready_seen++;
        if (want.above_ev) above_entries++;
        if (want.below_ev) below_entries++;
        check_field("percent_r", 32'(want.pct), 32'(out_percent_r));
        check_field("ready_res", 32'(want.ready), 32'(out_ready_res));
        check_field("above_flag", 32'(want.above), 32'(out_above_flag));
        check_field("below_flag", 32'(want.below), 32'(out_below_flag));
        check_field("above_event", 32'(want.above_ev), 32'(out_above_event));
        check_field("below_event", 32'(want.below_ev), 32'(out_below_event));
        check_field("above_total", want.above_cnt, out_above_total);
        check_field("below_total", want.below_cnt, out_below_total);
        check_field("sample_total", want.sample_cnt, out_sample_total);
      end
    end
  end

  // receiver stall pattern: free, light, heavy or bursty, with the mode drawn anew at random intervals
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
        end
      end
    endcase
  end

  function automatic logic signed [wrt_pkg::SAMPLE_W-1:0] draw_sample(input int mode);
    case (mode)
      0: return wrt_pkg::SAMPLE_W'($urandom);
      1: begin
        walk += $urandom_range(0, 2 * walk_step) - walk_step;
        if (walk > 32767) walk = 32767;
        if (walk < -32768) walk = -32768;
        return wrt_pkg::SAMPLE_W'(walk);
      end
      2: begin
        if (hold_left == 0) begin
          hold_val = int'($signed(wrt_pkg::SAMPLE_W'($urandom)));
          hold_left = $urandom_range(1, 20);
        end
        hold_left--;
        return wrt_pkg::SAMPLE_W'(hold_val);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic test_warmup_defaults();
    logic signed [wrt_pkg::SAMPLE_W-1:0] seq [15] = '{0, 32767, -32768, 1, -1, 100, -100,
                                                      5000, -5000, 12345, -12345, 32767,
                                                      -32768, 0, 32767};
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  task automatic test_length_clamping();
    load_settings(0, 0, -5120, -20480, 4'b0011);
    send_sample(16'sd7);
    send_sample(-16'sd9);
    load_settings(100, 2, -5120, -20480, 4'b0011);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
  endtask

  task automatic test_threshold_extremes();
    load_settings(4, 1, 0, -25600, 4'b1111);
    send_sample(16'sd10);
    send_sample(16'sd20);
    load_settings(4, 1, -25600, 0, 4'b1100);
    send_sample(16'sd5);
    send_sample(16'sd4);
  endtask

  task automatic test_never_ready();
    load_settings(3, 5, -5120, -20480, 4'b1111);
    send_sample(16'sd1000);
    send_sample(-16'sd1000);
  endtask

  task automatic test_random_phases();
    int         win;
    int         warm;
    int         eff;
    int         hi;
    int         lo;
    int         mode;
    logic [3:0] mask;
    for (int ph = 0; ph < 14; ph++) begin
      mask = (ph == 0) ? 4'hf : 4'($urandom_range(1, 15));
      case ($urandom_range(0, 9))
        0: win = 0;
        1: win = 64;
        2: win = $urandom_range(65, 127);
        3, 4: win = $urandom_range(33, 64);
        default: win = $urandom_range(1, 16);
      endcase
      if (!mask[0]) win = cfg_win;
      eff = (win == 0) ? 1 : ((win > wrt_pkg::WINDOW_MAX) ? wrt_pkg::WINDOW_MAX : win);
      case ($urandom_range(0, 9))
        0: warm = 0;
        1: warm = $urandom_range(eff, 127);
        default: warm = $urandom_range(1, eff);
      endcase
      case ($urandom_range(0, 7))
        0: begin
          hi = int'($signed(16'($urandom)));
          lo = int'($signed(16'($urandom)));
        end
        1: begin
          hi = 0;
          lo = -25600;
        end
        2: begin
          hi = -25600;
          lo = 0;
        end
        default: begin
          hi = -$urandom_range(0, 12800);
          lo = -$urandom_range(12800, 25600);
        end
      endcase
      load_settings(win, warm, hi, lo, mask);
      case ($urandom_range(0, 2))
        0: walk_step = 4;
        1: walk_step = 200;
        default: walk_step = 4000;
      endcase
      for (int k = 0; k < 130; k++) begin
        if (k % 16 == 0) begin
          case ($urandom_range(0, 19))
            0, 1, 2: mode = 0;
            3, 4, 5: mode = 2;
            6, 7: mode = 3;
            default: mode = 1;
          endcase
        end
        send_sample(draw_sample(mode));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_warmup_defaults();
    test_length_clamping();
    test_threshold_extremes();
    test_never_ready();
    test_random_phases();
    drain();
    repeat (100) @(posedge clk);
    $display("Checked %0d results (%0d ready) across %0d register settings;",
             results_seen, ready_seen, settings_loaded);
    $display("saw %0d overbought and %0d oversold entries, %0d mismatches.",
             above_entries, below_entries, misses);
    if (misses == 0 && pct_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results still pending", pct_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wrt_pkg.sv
sv/wrt_front.sv
sv/wrt_fifo.sv
sv/wrt_back.sv
sv/williams_r_threshold_tracker.sv
verif/tb.sv
